// ===== rtl/core/interval_arithmetic_unit_macros.svh =====
// assertion macros for the interval arithmetic unit
`ifndef INTERVAL_ARITHMETIC_UNIT_MACROS_SVH
`define INTERVAL_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IAU_ASSERT_IMP(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define IAU_ASSERT_NEXT(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define IAU_ASSERT_IMP(name, a, c)
`define IAU_ASSERT_NEXT(name, a, c)
`endif
`endif

// ===== rtl/core/iau_pkg.sv =====
// shared types and constants of the interval arithmetic unit
`default_nettype none
package iau_pkg;
  localparam int DEFAULT_FRAC_BITS = 16;

  typedef enum logic [2:0] {
    ACT_SUM  = 3'd0,
    ACT_DIFF = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_MIN  = 3'd4,
    ACT_MAX  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NEAR_ZERO = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/core/iau_if.sv =====
// operand, result and configuration channels of the interval arithmetic unit
`default_nettype none
interface iau_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [31:0] left_low;
  logic signed [31:0] left_high;
  logic signed [31:0] right_low;
  logic signed [31:0] right_high;
  modport source (output valid, action, left_low, left_high, right_low, right_high,
                  input ready);
  modport sink (input valid, action, left_low, left_high, right_low, right_high,
                output ready);
endinterface

interface iau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_low;
  logic signed [31:0] result_high;
  logic [1:0]         status;
  modport source (output valid, result_low, result_high, status, input ready);
  modport sink (input valid, result_low, result_high, status, output ready);
endinterface

interface iau_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/interval_arithmetic_unit.sv =====
// interval arithmetic unit: pipelined sum, difference, product, ratio, min and max
// One transaction enters per clock and one result leaves per clock while the result
// is taken; operands and results are in Q16.16 at the default FRAC_BITS.
// The pipeline depth is set by the ratio path, a restoring divider that resolves one
// quotient bit per pipeline stage over 32 + FRAC_BITS stages, four lanes wide.
// Every action runs through the same depth, so results keep their order. When
// the result is not taken the whole pipeline holds. The near-zero limit is
// written through cfg and is meant to change only while the unit is empty.
`default_nettype none
`include "interval_arithmetic_unit_macros.svh"
module interval_arithmetic_unit import iau_pkg::*; #(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst,
  iau_in_if.sink   operands,
  iau_out_if.source results,
  iau_cfg_if.sink  cfg
);
  localparam int NW = 32 + FRAC_BITS;
  localparam logic [15:0] NZ_RESET = 16'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef struct packed {
    logic               valid;
    logic [2:0]         action;
    logic               invalid;
    logic               near;
    logic [3:0]         qneg;
    logic signed [63:0] v0;
    logic signed [63:0] v1;
    logic signed [63:0] v2;
    logic signed [63:0] v3;
  } carry_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [33+NW-1:0] div_step(logic [32:0] rem, logic [NW-1:0] nq,
                                               logic [31:0] d);
    logic [32:0] trial;
    logic        qbit;
    trial = {rem[31:0], nq[NW-1]};
    qbit = trial >= {1'b0, d};
    return {(qbit ? trial - {1'b0, d} : trial), nq[NW-2:0], qbit};
  endfunction

  logic [15:0] near_zero_limit;
  logic        adv;

  // output register
  logic               o_valid;
  logic signed [31:0] o_lo;
  logic signed [31:0] o_hi;
  status_t            o_status;

  assign adv = !o_valid || results.ready;
  assign operands.ready = adv;
  assign cfg.ready = 1'b1;
  assign results.valid = o_valid;
  assign results.result_low = o_lo;
  assign results.result_high = o_hi;
  assign results.status = o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= NZ_RESET;
    end else if (cfg.valid) begin
      near_zero_limit <= cfg.data;
    end
  end

  // stage a: operand register
  logic               a_valid;
  logic [2:0]         a_action;
  logic signed [31:0] a_ll, a_lh, a_rl, a_rh;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= operands.valid;
    end
    if (adv) begin
      a_action <= operands.action;
      a_ll <= operands.left_low;
      a_lh <= operands.left_high;
      a_rl <= operands.right_low;
      a_rh <= operands.right_high;
    end
  end

  // stage b: checks, simple results, products, divider set-up
  carry_t      cy  [NW+1];
  logic [32:0] rem [NW+1][4];
  logic [NW-1:0] nq [NW+1][4];
  logic [31:0] dv  [NW+1][2];

  carry_t             b_next;
  logic signed [63:0] llx, lhx, rlx, rhx;
  logic signed [63:0] p0, p1, p2, p3;

  always_comb begin
    llx = 64'(a_ll);
    lhx = 64'(a_lh);
    rlx = 64'(a_rl);
    rhx = 64'(a_rh);
    p0 = a_ll * a_rl;
    p1 = a_ll * a_rh;
    p2 = a_lh * a_rl;
    p3 = a_lh * a_rh;
    b_next = '0;
    b_next.valid = a_valid;
    b_next.action = a_action;
    b_next.invalid = (a_ll >= a_lh) || (a_rl >= a_rh) || (a_action > ACT_MAX);
    b_next.near = (a_rl == 32'sd0) || (a_rh == 32'sd0) ||
                  (mag32(a_rl) < {16'd0, near_zero_limit}) ||
                  (mag32(a_rh) < {16'd0, near_zero_limit});
    b_next.qneg = {a_lh[31] ^ a_rh[31], a_lh[31] ^ a_rl[31],
                   a_ll[31] ^ a_rh[31], a_ll[31] ^ a_rl[31]};
    unique case (a_action)
      ACT_SUM: begin
        b_next.v0 = llx + rlx;
        b_next.v1 = lhx + rhx;
      end
      ACT_DIFF: begin
        b_next.v0 = llx - rhx;
        b_next.v1 = lhx - rlx;
      end
      ACT_MIN: begin
        b_next.v0 = (llx < rlx) ? llx : rlx;
        b_next.v1 = (lhx < rhx) ? lhx : rhx;
      end
      ACT_MAX: begin
        b_next.v0 = (llx > rlx) ? llx : rlx;
        b_next.v1 = (lhx > rhx) ? lhx : rhx;
      end
      default: begin
        b_next.v0 = p0 >>> FRAC_BITS;
        b_next.v1 = p1 >>> FRAC_BITS;
        b_next.v2 = p2 >>> FRAC_BITS;
        b_next.v3 = p3 >>> FRAC_BITS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cy[0].valid <= 1'b0;
    end else if (adv) begin
      cy[0].valid <= b_next.valid;
    end
    if (adv) begin
      cy[0].action <= b_next.action;
      cy[0].invalid <= b_next.invalid;
      cy[0].near <= b_next.near;
      cy[0].qneg <= b_next.qneg;
      cy[0].v0 <= b_next.v0;
      cy[0].v1 <= b_next.v1;
      cy[0].v2 <= b_next.v2;
      cy[0].v3 <= b_next.v3;
      for (int k = 0; k < 4; k++) begin
        rem[0][k] <= '0;
      end
      nq[0][0] <= {mag32(a_ll), FRAC_BITS'(0)};
      nq[0][1] <= {mag32(a_ll), FRAC_BITS'(0)};
      nq[0][2] <= {mag32(a_lh), FRAC_BITS'(0)};
      nq[0][3] <= {mag32(a_lh), FRAC_BITS'(0)};
      dv[0][0] <= mag32(a_rl);
      dv[0][1] <= mag32(a_rh);
    end
  end

  // divider stages, one quotient bit each
  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [33+NW-1:0] step [4];
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        step[k] = div_step(rem[s][k], nq[s][k], dv[s][k % 2]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cy[s+1].valid <= 1'b0;
      end else if (adv) begin
        cy[s+1].valid <= cy[s].valid;
      end
      if (adv) begin
        cy[s+1].action <= cy[s].action;
        cy[s+1].invalid <= cy[s].invalid;
        cy[s+1].near <= cy[s].near;
        cy[s+1].qneg <= cy[s].qneg;
        cy[s+1].v0 <= cy[s].v0;
        cy[s+1].v1 <= cy[s].v1;
        cy[s+1].v2 <= cy[s].v2;
        cy[s+1].v3 <= cy[s].v3;
        for (int k = 0; k < 4; k++) begin
          rem[s+1][k] <= step[k][33+NW-1:NW];
          nq[s+1][k] <= step[k][NW-1:0];
        end
        dv[s+1][0] <= dv[s][0];
        dv[s+1][1] <= dv[s][1];
      end
    end
  end

  // stage c: quotient signs and pairwise min/max
  carry_t             e;
  logic signed [63:0] q [4];
  logic signed [63:0] c0, c1, c2, c3;
  logic signed [63:0] c_alo_next, c_ahi_next, c_blo_next, c_bhi_next;
  logic               c_valid, c_invalid, c_near, c_pair;
  logic [2:0]         c_action;
  logic signed [63:0] c_alo, c_ahi, c_blo, c_bhi;

  always_comb begin
    e = cy[NW];
    for (int k = 0; k < 4; k++) begin
      q[k] = e.qneg[k] ? -64'(nq[NW][k]) : 64'(nq[NW][k]);
    end
    if (e.action == ACT_DIV) begin
      c0 = q[0];
      c1 = q[1];
      c2 = q[2];
      c3 = q[3];
    end else begin
      c0 = e.v0;
      c1 = e.v1;
      c2 = e.v2;
      c3 = e.v3;
    end
    if (e.action == ACT_DIV || e.action == ACT_MUL) begin
      c_alo_next = (c0 < c1) ? c0 : c1;
      c_ahi_next = (c0 < c1) ? c1 : c0;
      c_blo_next = (c2 < c3) ? c2 : c3;
      c_bhi_next = (c2 < c3) ? c3 : c2;
    end else begin
      c_alo_next = c0;
      c_ahi_next = c1;
      c_blo_next = c2;
      c_bhi_next = c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= e.valid;
    end
    if (adv) begin
      c_action <= e.action;
      c_invalid <= e.invalid;
      c_near <= e.near;
      c_pair <= (e.action == ACT_DIV) || (e.action == ACT_MUL);
      c_alo <= c_alo_next;
      c_ahi <= c_ahi_next;
      c_blo <= c_blo_next;
      c_bhi <= c_bhi_next;
    end
  end

  // stage d: final min/max, clamp, status
  logic signed [63:0] d_lo, d_hi;
  logic signed [31:0] d_lo32, d_hi32;
  logic               d_sat;
  status_t            d_status;
  logic signed [31:0] d_rlo, d_rhi;

  always_comb begin
    d_lo = c_pair ? ((c_alo < c_blo) ? c_alo : c_blo) : c_alo;
    d_hi = c_pair ? ((c_ahi > c_bhi) ? c_ahi : c_bhi) : c_ahi;
    d_sat = (d_lo > MAX32) || (d_lo < MIN32) || (d_hi > MAX32) || (d_hi < MIN32);
    d_lo32 = (d_lo > MAX32) ? 32'sh7fffffff : (d_lo < MIN32) ? 32'sh80000000 : d_lo[31:0];
    d_hi32 = (d_hi > MAX32) ? 32'sh7fffffff : (d_hi < MIN32) ? 32'sh80000000 : d_hi[31:0];
    d_rlo = d_lo32;
    d_rhi = d_hi32;
    priority if (c_invalid) begin
      d_status = ST_INVALID;
      d_rlo = '0;
      d_rhi = '0;
    end else if (c_action == ACT_DIV && c_near) begin
      d_status = ST_NEAR_ZERO;
      d_rlo = '0;
      d_rhi = '0;
    end else if (d_lo32 >= d_hi32) begin
      d_status = ST_INVALID;
    end else if (d_sat) begin
      d_status = ST_SATURATED;
    end else begin
      d_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= c_valid;
    end
    if (adv) begin
      o_lo <= d_rlo;
      o_hi <= d_rhi;
      o_status <= d_status;
    end
  end

  `IAU_ASSERT_NEXT(a_enter, operands.valid && operands.ready, a_valid)
  `IAU_ASSERT_IMP(a_near_zero, o_valid && o_status == ST_NEAR_ZERO, o_lo == 0 && o_hi == 0)
  `IAU_ASSERT_IMP(a_sat_order, o_valid && o_status == ST_SATURATED, o_lo < o_hi)
  `IAU_ASSERT_IMP(a_ok_order, o_valid && o_status == ST_OK, o_lo < o_hi)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench of the interval arithmetic unit: directed table, then random intervals
`timescale 1ns / 100ps
module tb;
  import iau_pkg::*;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    status_t            st;
  } interval_result_t;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] ll;
    logic signed [31:0] lh;
    logic signed [31:0] rl;
    logic signed [31:0] rh;
    bit                 typed;
    interval_result_t   res;
  } stim_row_t;

  localparam int  RANDOM_ITEMS = 1530;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  DRAIN_CYCLES = 120;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iau_in_if  op_if();
  iau_out_if res_if();
  iau_cfg_if cfg_if();

  interval_arithmetic_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (op_if),
    .results  (res_if),
    .cfg      (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [15:0]      zero_limit;
  interval_result_t pending_results[$];
  int               mismatches = 0;
  int               checked = 0;
  int               cycles = 0;
  bit               quiet;
  int               near_zero_seen = 0;
  int               sat_seen = 0;
  int               invalid_seen = 0;

  function automatic longint floor_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint trunc_div(longint a, longint d);
    return (a * 65536) / d;
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic interval_result_t predict_interval(logic [2:0] act,
      logic signed [31:0] ll, logic signed [31:0] lh,
      logic signed [31:0] rl, logic signed [31:0] rh);
    interval_result_t r;
    longint a, b, c, d, lo, hi;
    longint v[4];
    bit clamped;
    a = ll; b = lh; c = rl; d = rh;
    lo = 0; hi = 0; clamped = 0;
    r.st = ST_OK;
    if (a >= b || c >= d || act > ACT_MAX) begin
      r.st = ST_INVALID;
    end else if (act == ACT_DIV && (c == 0 || d == 0 ||
               magnitude(c) < zero_limit || magnitude(d) < zero_limit)) begin
      r.st = ST_NEAR_ZERO;
    end else begin
      case (act)
        ACT_SUM:  begin lo = a + c; hi = b + d; end
        ACT_DIFF: begin lo = a - d; hi = b - c; end
        ACT_MUL, ACT_DIV: begin
          if (act == ACT_MUL) begin
            v[0] = floor_mul(a, c); v[1] = floor_mul(a, d);
            v[2] = floor_mul(b, c); v[3] = floor_mul(b, d);
          end else begin
            v[0] = trunc_div(a, c); v[1] = trunc_div(a, d);
            v[2] = trunc_div(b, c); v[3] = trunc_div(b, d);
          end
          lo = v[0]; hi = v[0];
          for (int i = 1; i < 4; i++) begin
            if (v[i] < lo) lo = v[i];
            if (v[i] > hi) hi = v[i];
          end
        end
        ACT_MIN:  begin lo = a < c ? a : c; hi = b < d ? b : d; end
        default:  begin lo = a > c ? a : c; hi = b > d ? b : d; end
      endcase
      if (lo > S_MAX) begin lo = S_MAX; clamped = 1; end
      if (lo < S_MIN) begin lo = S_MIN; clamped = 1; end
      if (hi > S_MAX) begin hi = S_MAX; clamped = 1; end
      if (hi < S_MIN) begin hi = S_MIN; clamped = 1; end
      if (lo >= hi) r.st = ST_INVALID;
      else if (clamped) r.st = ST_SATURATED;
    end
    r.lo = lo[31:0];
    r.hi = hi[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] draw_endpoint();
    int m;
    m = $urandom_range(0, 9);
    case (m)
      0: return S_MAX - $urandom_range(0, 3);
      1: return S_MIN + $urandom_range(0, 3);
      2, 3: return $urandom;
      4: return $signed($urandom_range(0, 200)) - 100;
      5: return ($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(0, 300));
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  task automatic draw_interval(output logic signed [31:0] lo, output logic signed [31:0] hi);
    logic signed [31:0] x, y, t;
    x = draw_endpoint();
    y = draw_endpoint();
    if (x > y) begin t = x; x = y; y = t; end
    if (x == y) begin
      if (y == S_MAX) x = x - 1;
      else y = y + 1;
    end
    lo = x; hi = y;
  endtask

  task automatic cfg_write(input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    zero_limit = value;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] act,
      input logic signed [31:0] ll, input logic signed [31:0] lh,
      input logic signed [31:0] rl, input logic signed [31:0] rh,
      input bit typed, input interval_result_t typed_res);
    int gap;
    interval_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_if.valid      <= 1'b1;
    op_if.action     <= act;
    op_if.left_low   <= ll;
    op_if.left_high  <= lh;
    op_if.right_low  <= rl;
    op_if.right_high <= rh;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    r = typed ? typed_res : predict_interval(act, ll, lh, rl, rh);
    if (r.st == ST_NEAR_ZERO) near_zero_seen++;
    if (r.st == ST_SATURATED) sat_seen++;
    if (r.st == ST_INVALID) invalid_seen++;
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic stim_row_t row(logic [2:0] act, logic signed [31:0] ll,
      logic signed [31:0] lh, logic signed [31:0] rl, logic signed [31:0] rh,
      bit typed = 0, logic signed [31:0] lo = 0, logic signed [31:0] hi = 0,
      status_t st = ST_OK);
    stim_row_t s;
    s.act = act; s.ll = ll; s.lh = lh; s.rl = rl; s.rh = rh;
    s.typed = typed; s.res.lo = lo; s.res.hi = hi; s.res.st = st;
    return s;
  endfunction

  stim_row_t directed[$];

  function automatic void add_row(stim_row_t s);
    directed = {directed, s};
  endfunction

  initial begin
    op_if.valid = 1'b0;
    op_if.action = ACT_SUM;
    op_if.left_low = '0;
    op_if.left_high = '0;
    op_if.right_low = '0;
    op_if.right_high = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    zero_limit = 16'd66;
    quiet = 0;

    add_row(row(ACT_SUM, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000,
                1, 32'sh40000, 32'sh60000, ST_OK));
    add_row(row(ACT_DIFF, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000));
    add_row(row(ACT_MUL, -32'sh20000, 32'sh30000, -32'sh10000, 32'sh50000));
    add_row(row(ACT_DIV, 32'sh10000, 32'sh40000, 32'sh20000, 32'sh80000));
    add_row(row(ACT_DIV, -32'sh50000, 32'sh70000, -32'sh30000, 32'sh20000));
    add_row(row(ACT_MIN, -5, 100, 3, 40));
    add_row(row(ACT_MAX, -5, 100, 3, 400));
    add_row(row(ACT_SUM, 5, 5, 0, 1, 1, 0, 0, ST_INVALID));
    add_row(row(ACT_DIFF, 0, 1, 9, -9, 1, 0, 0, ST_INVALID));
    add_row(row(ACT_BAD6, 0, 1, 2, 3, 1, 0, 0, ST_INVALID));
    add_row(row(ACT_BAD7, S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 0, ST_INVALID));
    add_row(row(ACT_DIV, 1, 2, 0, 32'sh10000, 1, 0, 0, ST_NEAR_ZERO));
    add_row(row(ACT_DIV, 1, 2, -32'sh10000, 0, 1, 0, 0, ST_NEAR_ZERO));
    add_row(row(ACT_DIV, 1, 2, 65, 32'sh10000, 1, 0, 0, ST_NEAR_ZERO));
    add_row(row(ACT_DIV, 1, 2, -32'sh10000, -65, 1, 0, 0, ST_NEAR_ZERO));
    add_row(row(ACT_DIV, 32'sh10000, 32'sh20000, 66, 67));
    add_row(row(ACT_SUM, 0, S_MAX, 0, S_MAX, 1, 0, S_MAX, ST_SATURATED));
    add_row(row(ACT_SUM, S_MIN, 0, S_MIN, 0, 1, S_MIN, 0, ST_SATURATED));
    add_row(row(ACT_SUM, S_MAX - 1, S_MAX, S_MAX - 1, S_MAX,
                1, S_MAX, S_MAX, ST_INVALID));
    add_row(row(ACT_MUL, 32'sh40000000, S_MAX, 32'sh40000000, S_MAX,
                1, S_MAX, S_MAX, ST_INVALID));
    add_row(row(ACT_MUL, S_MIN, S_MAX, S_MIN, S_MAX));
    add_row(row(ACT_DIV, S_MIN, S_MAX, 66, S_MAX));
    add_row(row(ACT_MIN, S_MIN, S_MAX, S_MIN, S_MAX,
                1, S_MIN, S_MAX, ST_OK));
    add_row(row(ACT_MAX, 0, 1, 0, 1, 1, 0, 1, ST_OK));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].act, directed[i].ll, directed[i].lh,
                directed[i].rl, directed[i].rh, directed[i].typed, directed[i].res);

    for (int phase = 0; phase < 5; phase++) begin
      logic [15:0] lim;
      op_if.valid <= 1'b0;
      drain_results();
      case (phase)
        0: lim = 16'd0;
        1: lim = 16'hffff;
        2: lim = 16'($urandom_range(1, 16'hfffe));
        3: lim = 16'($urandom_range(1, 400));
        default: lim = 16'd66;
      endcase
      cfg_write(lim);
      @(posedge clk);
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        logic [2:0] act;
        logic signed [31:0] ll, lh, rl, rh;
        quiet = ((n / 60) % 4) == 3;
        draw_interval(ll, lh);
        draw_interval(rl, rh);
        act = 3'($urandom_range(ACT_SUM, ACT_MAX));
        if ($urandom_range(0, 9) == 0) begin
          act = 3'($urandom);
          ll = $urandom; lh = $urandom; rl = $urandom; rh = $urandom;
          if ($urandom_range(0, 1)) lh = ll;
        end else if (act == ACT_DIV && $urandom_range(0, 3) == 0) begin
          rl = $signed($urandom_range(0, 2 * lim + 2)) - $signed({16'd0, lim}) - 1;
          if (rl >= rh) rh = rl + 1 + $urandom_range(0, 2 * lim);
        end
        send_item(act, ll, lh, rl, rh, 0, '0);
      end
    end
    op_if.valid <= 1'b0;
    quiet = 0;
    drain_results();

    $display("checked %0d results over directed cases and five near-zero limit settings",
             checked);
    $display("status mix: %0d invalid, %0d near zero, %0d saturated",
             invalid_seen, near_zero_seen, sat_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int n;
    res_if.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    interval_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end else if (!rst && res_if.valid && res_if.ready) begin
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: lo %0d hi %0d status %0d",
                   res_if.result_low, res_if.result_high, res_if.status);
      end else begin
        want = pending_results.pop_front();
        if (res_if.result_low !== want.lo || res_if.result_high !== want.hi ||
            res_if.status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected lo %0d hi %0d status %0d, got lo %0d hi %0d status %0d",
                     want.lo, want.hi, want.st,
                     res_if.result_low, res_if.result_high, res_if.status);
        end
      end
    end
  end
endmodule

// ===== interval_arithmetic_unit.f =====
+incdir+rtl/core
rtl/core/iau_pkg.sv
rtl/core/iau_if.sv
rtl/core/interval_arithmetic_unit.sv
tb/tb.sv
